### sv/sbuod_pkg.sv
// Shared constants, mode codes and helpers for the sideband UART orientation detector.
package sbuod_pkg;

	localparam int MV_WIDTH_DEF = 12;
	localparam int MV_RESET_W   = 12;
	localparam int CNT_W        = 4;
	localparam int MODE_W       = 3;
	localparam int APB_DW       = 32;
	localparam int APB_AW       = 5;

	localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ON18   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FLIP18 = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ON33   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FLIP33 = 3'd4;
	localparam logic [MODE_W-1:0] MODE_AUTO   = 3'd5;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_CMD  = 1'b1;

	localparam logic [2:0] REG_LOW_LIMIT  = 3'd0;
	localparam logic [2:0] REG_MID_LOWER  = 3'd1;
	localparam logic [2:0] REG_MID_UPPER  = 3'd2;
	localparam logic [2:0] REG_HIGH_LOWER = 3'd3;
	localparam logic [2:0] REG_HIGH_UPPER = 3'd4;
	localparam logic [2:0] REG_DEBOUNCE   = 3'd5;

	localparam int RST_LOW_LIMIT  = 190;
	localparam int RST_MID_LOWER  = 1600;
	localparam int RST_MID_UPPER  = 1900;
	localparam int RST_HIGH_LOWER = 3000;
	localparam int RST_HIGH_UPPER = 3400;
	localparam logic [CNT_W-1:0] RST_DEBOUNCE = 4'd4;
	localparam logic [CNT_W-1:0] CNT_MAX      = 4'd15;

	// Threshold width: wide enough for the voltages and for the reset values.
	function automatic int th_width(input int mv_w);
		return (mv_w > MV_RESET_W) ? mv_w : MV_RESET_W;
	endfunction

	// Result flags derived from a mode.
	typedef struct packed {
		logic ref_low_voltage;
		logic lines_swapped;
		logic shifter_enabled;
	} mode_flags_t;

	function automatic mode_flags_t mode_flags(input logic [MODE_W-1:0] m);
		mode_flags_t f;
		f.ref_low_voltage = !((m == MODE_ON33) || (m == MODE_FLIP33));
		f.lines_swapped   = !((m == MODE_ON18) || (m == MODE_ON33));
		f.shifter_enabled = (m != MODE_OFF);
		return f;
	endfunction

endpackage

### sv/sbuod_cfg.sv
// APB register file holding the voltage thresholds and the debounce limit.
module sbuod_cfg #(
	parameter int MV_WIDTH = sbuod_pkg::MV_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      psel,
	input  logic                                      penable,
	input  logic                                      pwrite,
	input  logic [sbuod_pkg::APB_AW-1:0]              paddr,
	input  logic [sbuod_pkg::APB_DW-1:0]              pwdata,
	output logic [sbuod_pkg::APB_DW-1:0]              prdata,
	output logic                                      pready,
	output logic [sbuod_pkg::th_width(MV_WIDTH)-1:0]  low_limit_mv,
	output logic [sbuod_pkg::th_width(MV_WIDTH)-1:0]  mid_lower_mv,
	output logic [sbuod_pkg::th_width(MV_WIDTH)-1:0]  mid_upper_mv,
	output logic [sbuod_pkg::th_width(MV_WIDTH)-1:0]  high_lower_mv,
	output logic [sbuod_pkg::th_width(MV_WIDTH)-1:0]  high_upper_mv,
	output logic [sbuod_pkg::CNT_W-1:0]               debounce_limit
);
	import sbuod_pkg::*;

	localparam int TH_W = th_width(MV_WIDTH);

	logic [TH_W-1:0]  low_limit_q, mid_lower_q, mid_upper_q, high_lower_q, high_upper_q;
	logic [CNT_W-1:0] debounce_q;
	logic [TH_W-1:0]  wr_mv;
	logic [2:0]       reg_idx;
	logic             wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;
	// Keep only the low MV_WIDTH bits of a written voltage.
	assign wr_mv   = TH_W'(pwdata[MV_WIDTH-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q  <= TH_W'(RST_LOW_LIMIT);
			mid_lower_q  <= TH_W'(RST_MID_LOWER);
			mid_upper_q  <= TH_W'(RST_MID_UPPER);
			high_lower_q <= TH_W'(RST_HIGH_LOWER);
			high_upper_q <= TH_W'(RST_HIGH_UPPER);
			debounce_q   <= RST_DEBOUNCE;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_LOW_LIMIT:  low_limit_q  <= wr_mv;
				REG_MID_LOWER:  mid_lower_q  <= wr_mv;
				REG_MID_UPPER:  mid_upper_q  <= wr_mv;
				REG_HIGH_LOWER: high_lower_q <= wr_mv;
				REG_HIGH_UPPER: high_upper_q <= wr_mv;
				REG_DEBOUNCE:   debounce_q   <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LOW_LIMIT:  prdata = APB_DW'(low_limit_q);
			REG_MID_LOWER:  prdata = APB_DW'(mid_lower_q);
			REG_MID_UPPER:  prdata = APB_DW'(mid_upper_q);
			REG_HIGH_LOWER: prdata = APB_DW'(high_lower_q);
			REG_HIGH_UPPER: prdata = APB_DW'(high_upper_q);
			REG_DEBOUNCE:   prdata = APB_DW'(debounce_q);
			default:        prdata = '0;
		endcase
	end

	assign low_limit_mv   = low_limit_q;
	assign mid_lower_mv   = mid_lower_q;
	assign mid_upper_mv   = mid_upper_q;
	assign high_lower_mv  = high_lower_q;
	assign high_upper_mv  = high_upper_q;
	assign debounce_limit = debounce_q;

endmodule

### sv/sbuod_class.sv
// Voltage window compares: orientation classification and idle check.
module sbuod_class #(
	parameter int MV_WIDTH = sbuod_pkg::MV_WIDTH_DEF
) (
	input  logic [MV_WIDTH-1:0]                       line_one_mv,
	input  logic [MV_WIDTH-1:0]                       line_two_mv,
	input  logic [sbuod_pkg::th_width(MV_WIDTH)-1:0]  low_limit_mv,
	input  logic [sbuod_pkg::th_width(MV_WIDTH)-1:0]  mid_lower_mv,
	input  logic [sbuod_pkg::th_width(MV_WIDTH)-1:0]  mid_upper_mv,
	input  logic [sbuod_pkg::th_width(MV_WIDTH)-1:0]  high_lower_mv,
	input  logic [sbuod_pkg::th_width(MV_WIDTH)-1:0]  high_upper_mv,
	output logic [sbuod_pkg::MODE_W-1:0]              found_mode,
	output logic                                      lines_idle
);
	import sbuod_pkg::*;

	localparam int TH_W = th_width(MV_WIDTH);

	logic [TH_W-1:0] a, b;
	logic a_low, b_low, a_mid, b_mid, a_high, b_high;

	assign a = TH_W'(line_one_mv);
	assign b = TH_W'(line_two_mv);

	assign a_low  = a < low_limit_mv;
	assign b_low  = b < low_limit_mv;
	assign a_mid  = (a > mid_lower_mv) && (a < mid_upper_mv);
	assign b_mid  = (b > mid_lower_mv) && (b < mid_upper_mv);
	assign a_high = (a > high_lower_mv) && (a < high_upper_mv);
	assign b_high = (b > high_lower_mv) && (b < high_upper_mv);

	always_comb begin
		priority if (a_low && b_mid)  found_mode = MODE_ON18;
		else if (b_low && a_mid)      found_mode = MODE_FLIP18;
		else if (a_low && b_high)     found_mode = MODE_ON33;
		else if (b_low && a_high)     found_mode = MODE_FLIP33;
		else                          found_mode = MODE_OFF;
	end

	assign lines_idle = (a_mid && b_mid) || (a_high && b_high);

endmodule

### sv/sbu_uart_orientation_detect_unit.sv
// Top level of the sideband UART orientation detector: state update and result register.
// The result of an item is registered and valid in the cycle after it is accepted.
// Throughput: one item per cycle unless the result side stalls; the classifier compares
//   and the debounce counter settle between the input ports and the mode/result registers.
// A held result does not block intake unless it is stalled: ready = !result_valid | result_ready.
// Reset (arst_n low, asynchronous): mode off, auto detection on, count zero,
//   thresholds 190/1600/1900/3000/3400 mV, debounce limit 4, no result pending.
module sbu_uart_orientation_detect_unit #(
	parameter int MV_WIDTH = sbuod_pkg::MV_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input items
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic                          opcode,
	input  logic [2:0]                    mode_request,
	input  logic [MV_WIDTH-1:0]           line_one_mv,
	input  logic [MV_WIDTH-1:0]           line_two_mv,
	// Result items
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [sbuod_pkg::MODE_W-1:0]  uart_mode,
	output logic                          auto_active,
	output logic                          ref_low_voltage,
	output logic                          lines_swapped,
	output logic                          shifter_enabled,
	output logic                          mode_changed,
	// Configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sbuod_pkg::APB_AW-1:0]  paddr,
	input  logic [sbuod_pkg::APB_DW-1:0]  pwdata,
	output logic [sbuod_pkg::APB_DW-1:0]  prdata,
	output logic                          pready
);
	import sbuod_pkg::*;

	localparam int TH_W = th_width(MV_WIDTH);

	logic [TH_W-1:0]   low_limit_mv, mid_lower_mv, mid_upper_mv, high_lower_mv, high_upper_mv;
	logic [CNT_W-1:0]  debounce_limit;
	logic [MODE_W-1:0] found_mode;
	logic              lines_idle;

	// Detector state
	logic [MODE_W-1:0] mode_q, mode_nxt;
	logic              auto_q, auto_nxt;
	logic [CNT_W-1:0]  cnt_q, cnt_nxt, cnt_inc;
	logic [MODE_W-1:0] target;
	logic              disagree;

	// Result register
	logic              res_valid_q;
	logic [MODE_W-1:0] res_mode_q;
	logic              res_auto_q;
	mode_flags_t       res_flags_q;
	logic              res_changed_q;

	logic accept;

	sbuod_cfg #(.MV_WIDTH(MV_WIDTH)) u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.low_limit_mv   (low_limit_mv),
		.mid_lower_mv   (mid_lower_mv),
		.mid_upper_mv   (mid_upper_mv),
		.high_lower_mv  (high_lower_mv),
		.high_upper_mv  (high_upper_mv),
		.debounce_limit (debounce_limit)
	);

	sbuod_class #(.MV_WIDTH(MV_WIDTH)) u_class (
		.line_one_mv   (line_one_mv),
		.line_two_mv   (line_two_mv),
		.low_limit_mv  (low_limit_mv),
		.mid_lower_mv  (mid_lower_mv),
		.mid_upper_mv  (mid_upper_mv),
		.high_lower_mv (high_lower_mv),
		.high_upper_mv (high_upper_mv),
		.found_mode    (found_mode),
		.lines_idle    (lines_idle)
	);

	// Take a new item whenever the result slot is empty or being drained.
	assign item_ready = !res_valid_q || result_ready;
	assign accept     = item_valid && item_ready;

	// While off, a tick disagrees when it finds an orientation; while on, when
	// the lines do not idle at a matching level. Off is the target in that case.
	assign disagree = (mode_q == MODE_OFF) ? (found_mode != MODE_OFF) : !lines_idle;
	assign target   = (mode_q == MODE_OFF) ? found_mode : MODE_OFF;
	// Saturate the count at its top value.
	assign cnt_inc  = (cnt_q < CNT_MAX) ? cnt_q + CNT_W'(1) : cnt_q;

	always_comb begin
		mode_nxt = mode_q;
		auto_nxt = auto_q;
		cnt_nxt  = cnt_q;
		if (opcode == OP_CMD) begin
			// Commands leave the count alone; unused request codes do nothing.
			if (mode_request == MODE_AUTO) begin
				auto_nxt = 1'b1;
				mode_nxt = found_mode;
			end else if (mode_request <= MODE_FLIP33) begin
				auto_nxt = 1'b0;
				mode_nxt = mode_request;
			end
		end else if (auto_q) begin
			if (!disagree) begin
				cnt_nxt = '0;
			end else if (cnt_inc > debounce_limit) begin
				cnt_nxt  = '0;
				mode_nxt = target;
			end else begin
				cnt_nxt = cnt_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_OFF;
			auto_q      <= 1'b1;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q      <= mode_nxt;
				auto_q      <= auto_nxt;
				cnt_q       <= cnt_nxt;
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: loaded on accept, held otherwise.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_mode_q    <= mode_nxt;
			res_auto_q    <= auto_nxt;
			res_flags_q   <= mode_flags(mode_nxt);
			res_changed_q <= (mode_nxt != mode_q);
		end
	end

	assign result_valid    = res_valid_q;
	assign uart_mode       = res_mode_q;
	assign auto_active     = res_auto_q;
	assign ref_low_voltage = res_flags_q.ref_low_voltage;
	assign lines_swapped   = res_flags_q.lines_swapped;
	assign shifter_enabled = res_flags_q.shifter_enabled;
	assign mode_changed    = res_changed_q;

	// A manual command sets the mode and drops auto detection.
	a_manual_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_CMD && mode_request <= MODE_FLIP33)
		|=> (mode_q == $past(mode_request) && !auto_q && uart_mode == mode_q))
		else $error("manual command not applied");

	// A tick in manual mode leaves mode and count untouched.
	a_manual_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_TICK && !auto_q)
		|=> ($stable(mode_q) && $stable(cnt_q) && !auto_q))
		else $error("manual tick changed state");

	// State only moves when an item is taken.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> ($stable(mode_q) && $stable(auto_q) && $stable(cnt_q)))
		else $error("state changed without an item");

	// The change flag reports exactly a mode transition.
	a_changed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (mode_changed == (mode_q != $past(mode_q))))
		else $error("mode_changed disagrees with mode transition");

endmodule

### test/orient_check_pkg.sv
// Expected-result tracker and result type for the orientation detector testbench.
package orient_check_pkg;
	import sbuod_pkg::*;

	localparam int MV_W = MV_WIDTH_DEF;

	typedef struct packed {
		logic [MODE_W-1:0] uart_mode;
		logic              auto_active;
		logic              ref_low_voltage;
		logic              lines_swapped;
		logic              shifter_enabled;
		logic              mode_changed;
	} orient_result_t;

	class orient_tracker;
		logic [MV_W-1:0]   low_limit;
		logic [MV_W-1:0]   mid_lower;
		logic [MV_W-1:0]   mid_upper;
		logic [MV_W-1:0]   high_lower;
		logic [MV_W-1:0]   high_upper;
		logic [CNT_W-1:0]  debounce;
		logic [MODE_W-1:0] mode;
		logic              auto_en;
		logic [CNT_W-1:0]  disagree_cnt;
		orient_result_t    expected_q[$];
		int                errors;

		function new();
			low_limit    = MV_W'(RST_LOW_LIMIT);
			mid_lower    = MV_W'(RST_MID_LOWER);
			mid_upper    = MV_W'(RST_MID_UPPER);
			high_lower   = MV_W'(RST_HIGH_LOWER);
			high_upper   = MV_W'(RST_HIGH_UPPER);
			debounce     = RST_DEBOUNCE;
			mode         = MODE_OFF;
			auto_en      = 1'b1;
			disagree_cnt = '0;
			errors       = 0;
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= 10)
				$display("%s", what);
		endfunction

		function bit is_low(logic [MV_W-1:0] mv);
			return mv < low_limit;
		endfunction

		function bit in_mid(logic [MV_W-1:0] mv);
			return (mv > mid_lower) && (mv < mid_upper);
		endfunction

		function bit in_high(logic [MV_W-1:0] mv);
			return (mv > high_lower) && (mv < high_upper);
		endfunction

		function logic [MODE_W-1:0] classify_lines(logic [MV_W-1:0] a, logic [MV_W-1:0] b);
			if (is_low(a) && in_mid(b))  return MODE_ON18;
			if (is_low(b) && in_mid(a))  return MODE_FLIP18;
			if (is_low(a) && in_high(b)) return MODE_ON33;
			if (is_low(b) && in_high(a)) return MODE_FLIP33;
			return MODE_OFF;
		endfunction

		// Saturating run of disagreeing ticks; switch once it passes the limit.
		function void count_disagree(logic [MODE_W-1:0] target);
			if (disagree_cnt != CNT_MAX)
				disagree_cnt++;
			if (disagree_cnt > debounce) begin
				disagree_cnt = '0;
				mode = target;
			end
		endfunction

		function void accept_item(logic op, logic [2:0] req, logic [MV_W-1:0] a,
				logic [MV_W-1:0] b);
			logic [MODE_W-1:0] prior;
			logic [MODE_W-1:0] found;
			orient_result_t    r;
			prior = mode;
			if (op == OP_CMD) begin
				if (req == MODE_AUTO) begin
					auto_en = 1'b1;
					mode = classify_lines(a, b);
				end else if (req <= MODE_FLIP33) begin
					auto_en = 1'b0;
					mode = req;
				end
			end else if (auto_en) begin
				if (mode == MODE_OFF) begin
					found = classify_lines(a, b);
					if (found != MODE_OFF)
						count_disagree(found);
					else
						disagree_cnt = '0;
				end else if (!((in_mid(a) && in_mid(b)) || (in_high(a) && in_high(b)))) begin
					count_disagree(MODE_OFF);
				end else begin
					disagree_cnt = '0;
				end
			end
			r.uart_mode       = mode;
			r.auto_active     = auto_en;
			r.ref_low_voltage = !((mode == MODE_ON33) || (mode == MODE_FLIP33));
			r.lines_swapped   = !((mode == MODE_ON18) || (mode == MODE_ON33));
			r.shifter_enabled = (mode != MODE_OFF);
			r.mode_changed    = (mode != prior);
			expected_q.push_back(r);
		endfunction

		function string fmt(orient_result_t r);
			return $sformatf("mode %0d auto %0b ref18 %0b swap %0b shift %0b chg %0b",
				r.uart_mode, r.auto_active, r.ref_low_voltage, r.lines_swapped,
				r.shifter_enabled, r.mode_changed);
		endfunction

		function void check_result(orient_result_t got);
			orient_result_t want;
			if (expected_q.size() == 0) begin
				flag({"unexpected result: ", fmt(got)});
				return;
			end
			want = expected_q.pop_front();
			if (got.uart_mode !== want.uart_mode || got.auto_active !== want.auto_active ||
					got.ref_low_voltage !== want.ref_low_voltage ||
					got.lines_swapped !== want.lines_swapped ||
					got.shifter_enabled !== want.shifter_enabled ||
					got.mode_changed !== want.mode_changed)
				flag({"result mismatch: expected ", fmt(want), " got ", fmt(got)});
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_LOW_LIMIT:  low_limit  = val[MV_W-1:0];
				REG_MID_LOWER:  mid_lower  = val[MV_W-1:0];
				REG_MID_UPPER:  mid_upper  = val[MV_W-1:0];
				REG_HIGH_LOWER: high_lower = val[MV_W-1:0];
				REG_HIGH_UPPER: high_upper = val[MV_W-1:0];
				REG_DEBOUNCE:   debounce   = val[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(logic [2:0] idx);
			case (idx)
				REG_LOW_LIMIT:  return 32'(low_limit);
				REG_MID_LOWER:  return 32'(mid_lower);
				REG_MID_UPPER:  return 32'(mid_upper);
				REG_HIGH_LOWER: return 32'(high_lower);
				REG_HIGH_UPPER: return 32'(high_upper);
				REG_DEBOUNCE:   return 32'(debounce);
				default:        return 32'd0;
			endcase
		endfunction
	endclass

endpackage

### test/testbench.sv
// Testbench for the sideband UART orientation detector: directed and random items, checked.
module testbench;
	import sbuod_pkg::*;
	import orient_check_pkg::*;

	// Mode request codes that the block must ignore.
	localparam logic [2:0] REQ_UNUSED_A = 3'd6;
	localparam logic [2:0] REQ_UNUSED_B = 3'd7;

	// Voltage classes that the random part draws line levels from.
	typedef enum int {KIND_LOW, KIND_MID, KIND_HIGH, KIND_EDGE, KIND_ANY} mv_kind_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                item_valid;
	logic                item_ready;
	logic                opcode;
	logic [2:0]          mode_request;
	logic [MV_W-1:0]     line_one_mv;
	logic [MV_W-1:0]     line_two_mv;
	logic                result_valid;
	logic                result_ready = 1'b0;
	logic [MODE_W-1:0]   uart_mode;
	logic                auto_active;
	logic                ref_low_voltage;
	logic                lines_swapped;
	logic                shifter_enabled;
	logic                mode_changed;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	orient_tracker  tracker;
	orient_result_t observed;
	bit             idle_on = 1'b0;

	sbu_uart_orientation_detect_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.opcode          (opcode),
		.mode_request    (mode_request),
		.line_one_mv     (line_one_mv),
		.line_two_mv     (line_two_mv),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.uart_mode       (uart_mode),
		.auto_active     (auto_active),
		.ref_low_voltage (ref_low_voltage),
		.lines_swapped   (lines_swapped),
		.shifter_enabled (shifter_enabled),
		.mode_changed    (mode_changed),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stall the result side about a third of the time while idling is on.
	always @(negedge clk) begin
		result_ready <= !idle_on || ($urandom_range(99, 0) >= 33);
	end

	// Sample both handshakes at the rising edge. Check results before noting the
	// new item, so a result can never be matched against the item accepted with it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				observed.uart_mode       = uart_mode;
				observed.auto_active     = auto_active;
				observed.ref_low_voltage = ref_low_voltage;
				observed.lines_swapped   = lines_swapped;
				observed.shifter_enabled = shifter_enabled;
				observed.mode_changed    = mode_changed;
				tracker.check_result(observed);
			end
			if (item_valid && item_ready)
				tracker.accept_item(opcode, mode_request, line_one_mv, line_two_mv);
		end
	end

	// Present one item at the falling edge, with random gaps first while idling
	// is on, and hold it until the rising edge at which it is taken.
	task automatic send_item(logic op, logic [2:0] req, logic [MV_W-1:0] a,
			logic [MV_W-1:0] b);
		@(negedge clk);
		while (idle_on && ($urandom_range(99, 0) < 33)) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid   <= 1'b1;
		opcode       <= op;
		mode_request <= req;
		line_one_mv  <= a;
		line_two_mv  <= b;
		do @(posedge clk); while (!item_ready);
	endtask

	// Ticks carry a random mode request; the block must not look at it.
	task automatic tick(logic [MV_W-1:0] a, logic [MV_W-1:0] b);
		send_item(OP_TICK, 3'($urandom_range(7, 0)), a, b);
	endtask

	// Drop valid and wait until every expected result has been taken.
	task automatic wait_drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (tracker.expected_q.size() != 0)
			@(posedge clk);
	endtask

	// Write one register, then read it back in a second transfer.
	task automatic apb_write(logic [2:0] idx, int value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_reg(idx, 32'(value));
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== tracker.reg_value(idx))
			tracker.flag($sformatf("register %0d read back %0d, expected %0d",
				idx, prdata, tracker.reg_value(idx)));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Reconfigure only with the block idle: drain first, then write all six.
	task automatic load_config(int low, int mid_lo, int mid_hi, int high_lo, int high_hi,
			int db);
		wait_drain();
		apb_write(REG_LOW_LIMIT, low);
		apb_write(REG_MID_LOWER, mid_lo);
		apb_write(REG_MID_UPPER, mid_hi);
		apb_write(REG_HIGH_LOWER, high_lo);
		apb_write(REG_HIGH_UPPER, high_hi);
		apb_write(REG_DEBOUNCE, db);
	endtask

	// Draw a line voltage of the given class under the current thresholds;
	// fall back to any value where the class is empty.
	function automatic logic [MV_W-1:0] pick_mv(mv_kind_t kind);
		int lo;
		int hi;
		case (kind)
			KIND_LOW: begin
				hi = int'(tracker.low_limit);
				if (hi > 0)
					return MV_W'($urandom_range(hi - 1, 0));
			end
			KIND_MID: begin
				lo = int'(tracker.mid_lower);
				hi = int'(tracker.mid_upper);
				if (hi - lo > 1)
					return MV_W'($urandom_range(hi - 1, lo + 1));
			end
			KIND_HIGH: begin
				lo = int'(tracker.high_lower);
				hi = int'(tracker.high_upper);
				if (hi - lo > 1)
					return MV_W'($urandom_range(hi - 1, lo + 1));
			end
			KIND_EDGE: begin
				case ($urandom_range(4, 0))
					0:       lo = int'(tracker.low_limit);
					1:       lo = int'(tracker.mid_lower);
					2:       lo = int'(tracker.mid_upper);
					3:       lo = int'(tracker.high_lower);
					default: lo = int'(tracker.high_upper);
				endcase
				return MV_W'(lo + $urandom_range(2, 0) - 1);
			end
			default: ;
		endcase
		return MV_W'($urandom_range(4095, 0));
	endfunction

	// Mostly runs of ticks from one line scene, some long enough to cross the
	// debounce limit, with stray ticks and mode commands mixed in. Ignored items
	// (manual-mode ticks, unused requests) do not count toward n.
	task automatic run_random(int n);
		int          done_cnt;
		int          reps;
		mv_kind_t    ka;
		mv_kind_t    kb;
		logic [2:0]  req;
		bit          counts;
		done_cnt = 0;
		while (done_cnt < n) begin
			case ($urandom_range(7, 0))
				0:       begin ka = KIND_LOW;  kb = KIND_MID;  end
				1:       begin ka = KIND_MID;  kb = KIND_LOW;  end
				2:       begin ka = KIND_LOW;  kb = KIND_HIGH; end
				3:       begin ka = KIND_HIGH; kb = KIND_LOW;  end
				4:       begin ka = KIND_MID;  kb = KIND_MID;  end
				5:       begin ka = KIND_HIGH; kb = KIND_HIGH; end
				6:       begin ka = KIND_EDGE; kb = KIND_EDGE; end
				default: begin ka = KIND_ANY;  kb = KIND_ANY;  end
			endcase
			if ($urandom_range(99, 0) < 12) begin
				req = ($urandom_range(1, 0) == 1) ? MODE_AUTO : 3'($urandom_range(7, 0));
				send_item(OP_CMD, req, pick_mv(ka), pick_mv(kb));
				if (req <= MODE_AUTO)
					done_cnt++;
			end else begin
				reps = $urandom_range(int'(tracker.debounce) + 3, 1);
				repeat (reps) begin
					counts = tracker.auto_en;
					if ($urandom_range(9, 0) == 0)
						tick(pick_mv(KIND_ANY), pick_mv(KIND_ANY));
					else
						tick(pick_mv(ka), pick_mv(kb));
					if (counts)
						done_cnt++;
				end
			end
		end
	endtask

	initial begin
		tracker      = new();
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		opcode       = OP_TICK;
		mode_request = MODE_OFF;
		line_one_mv  = '0;
		line_two_mv  = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at reset settings, no idling on either side.
		// Unused requests: nothing may change.
		send_item(OP_CMD, REQ_UNUSED_A, 12'd0, 12'd0);
		send_item(OP_CMD, REQ_UNUSED_B, 12'd4095, 12'd4095);
		// Off in auto: five straight 1.8 V ticks switch to on 1.8V on the fifth.
		repeat (5) tick(12'd0, 12'd1750);
		// On: one disagreeing tick, then idle levels clear the count.
		tick(12'd4095, 12'd0);
		tick(12'd1750, 12'd1750);
		tick(12'd3200, 12'd3200);
		// On: five ticks with no idle level fall back to off.
		repeat (5) tick(12'd0, 12'd0);
		// Off: one flip 3.3V tick, then a tick that finds nothing clears the count.
		tick(12'd3200, 12'd0);
		tick(12'd0, 12'd0);
		// Manual commands; a tick in manual mode changes nothing.
		send_item(OP_CMD, MODE_ON18, 12'd4095, 12'd0);
		tick(12'd0, 12'd0);
		send_item(OP_CMD, MODE_FLIP18, 12'd0, 12'd4095);
		send_item(OP_CMD, MODE_ON33, 12'd0, 12'd0);
		send_item(OP_CMD, MODE_FLIP33, 12'd4095, 12'd4095);
		send_item(OP_CMD, MODE_OFF, 12'd2048, 12'd2048);
		// Auto commands classify at once, one per orientation.
		send_item(OP_CMD, MODE_AUTO, 12'd3200, 12'd100);
		send_item(OP_CMD, MODE_AUTO, 12'd1750, 12'd0);
		send_item(OP_CMD, MODE_AUTO, 12'd0, 12'd3300);
		send_item(OP_CMD, MODE_AUTO, 12'd189, 12'd1899);
		send_item(OP_CMD, REQ_UNUSED_B, 12'd0, 12'd0);

		// Long stretch with no idling, still at reset settings.
		run_random(100);

		// Turn idling on and step through settings, extremes among them.
		idle_on = 1'b1;
		load_config(190, 1600, 1900, 3000, 3400, 0);
		run_random(100);
		// Counter saturates, limit never exceeded.
		load_config(190, 1600, 1900, 3000, 3400, 15);
		run_random(80);
		load_config(300, 1500, 2100, 2800, 3600, 14);
		run_random(80);
		// Everything but full scale counts as low; windows as wide as they go.
		load_config(4095, 0, 4095, 0, 4095, 1);
		run_random(60);
		// Nothing is low and both windows are empty.
		load_config(0, 2048, 2048, 4095, 4095, 2);
		run_random(40);
		// Random ordered thresholds.
		repeat (2) begin
			automatic int low     = $urandom_range(600, 0);
			automatic int mid_lo  = $urandom_range(2000, low);
			automatic int mid_hi  = mid_lo + $urandom_range(600, 2);
			automatic int high_lo = mid_hi + $urandom_range(600, 0);
			automatic int high_hi = high_lo + $urandom_range(800, 2);
			load_config(low, mid_lo, mid_hi, high_lo, high_hi, $urandom_range(14, 0));
			run_random(100);
		end

		// Hold until every result is in, then let the last one settle.
		wait_drain();
		repeat (4) @(posedge clk);
		if (tracker.errors == 0 && tracker.expected_q.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// Safety net: end the run if the handshakes ever hang.
	initial begin
		#4000000;
		$display("testbench: errors");
		$finish;
	end

endmodule
